>>> rtl/pirle_pkg.sv
// Shared types and constants for the palette index run-length encoder.
package pirle_pkg;

    localparam int COLOR_W = 24;
    localparam int COUNT_W = 13;
    localparam int INDEX_W = 8;
    localparam int USED_W  = 9;
    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd16;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SEARCH,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_SECOND
    } t_back_state;

    // One classified pixel, handed from the lookup side to the run builder.
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               eol;
        logic [USED_W-1:0]  used;
        logic               ovf;
    } t_run_ent;

endpackage

>>> rtl/pirle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pirle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/pirle_fifo.sv
// Small register queue between the palette lookup and the run builder.
module pirle_fifo #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/pirle_front.sv
// Pixel intake: palette scan, new-colour allocation and overflow tracking.
module pirle_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tvalid,
    output logic                           o_tready,
    input  logic [pirle_pkg::COLOR_W-1:0]  i_color,
    input  logic                           i_eol,
    output logic                           o_push,
    output pirle_pkg::t_run_ent            o_ent,
    input  logic                           i_full
);

    import pirle_pkg::*;

    localparam int IW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    t_front_state     r_state, n_state;
    logic [COLOR_W-1:0] r_color, n_color;
    logic             r_eol, n_eol;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]    r_chk, n_chk;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_ovf, n_ovf;

    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    logic [COLOR_W-1:0] w_wr_data;
    logic [IW-1:0]    w_rd_addr;
    logic [COLOR_W-1:0] w_rd_data;

    pirle_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_wr_addr = IW'(r_cnt);
    assign w_rd_addr = (r_state == F_SEARCH) ? r_chk + IW'(1) : '0;

    always_comb begin
        n_state   = r_state;
        n_color   = r_color;
        n_eol     = r_eol;
        n_cnt     = r_cnt;
        n_chk     = r_chk;
        n_idx     = r_idx;
        n_ovf     = r_ovf;
        o_tready  = 1'b0;
        o_push    = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_data = r_color;
        o_ent.idx  = INDEX_W'(r_idx);
        o_ent.eol  = r_eol;
        o_ent.used = USED_W'(r_cnt);
        o_ent.ovf  = r_ovf;
        unique case (r_state)
            F_IDLE: begin
                o_tready = 1'b1;
                if (i_tvalid) begin
                    n_color = i_color;
                    n_eol   = i_eol;
                    if (r_cnt == '0) begin
                        w_wr_en   = 1'b1;
                        w_wr_data = i_color;
                        n_cnt     = CW'(1);
                        n_idx     = '0;
                        n_state   = F_PUSH;
                    end else begin
                        n_chk   = '0;
                        n_state = F_SEARCH;
                    end
                end
            end
            F_SEARCH: begin
                if (w_rd_data == r_color) begin
                    n_idx   = r_chk;
                    n_state = F_PUSH;
                end else if (CW'(r_chk) + CW'(1) == r_cnt) begin
                    if (r_cnt == CW'(PALETTE_DEPTH)) begin
                        n_ovf = 1'b1;
                        n_idx = '0;
                    end else begin
                        w_wr_en = 1'b1;
                        n_idx   = IW'(r_cnt);
                        n_cnt   = r_cnt + CW'(1);
                    end
                    n_state = F_PUSH;
                end else begin
                    n_chk = r_chk + IW'(1);
                end
            end
            F_PUSH: begin
                o_push = !i_full;
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_color <= n_color;
        r_eol   <= n_eol;
        r_chk   <= n_chk;
        r_idx   <= n_idx;
    end

endmodule

>>> rtl/pirle_back.sv
// Run builder: merges indices into runs and drives the registered output.
module pirle_back #(
    parameter int RUN_MAX = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [pirle_pkg::LIMIT_W-1:0]  i_cfg_wr_data,
    input  logic                           i_empty,
    input  pirle_pkg::t_run_ent            i_ent,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [pirle_pkg::COUNT_W-1:0]  o_count,
    output logic [pirle_pkg::INDEX_W-1:0]  o_index,
    output logic                           o_last,
    output logic [pirle_pkg::USED_W-1:0]   o_used,
    output logic                           o_warn,
    output logic                           o_ovf
);

    import pirle_pkg::*;

    localparam int LW = $clog2(RUN_MAX + 1);
    localparam int EW = (LW > COUNT_W) ? LW : COUNT_W;

    t_back_state        r_state, n_state;
    logic [INDEX_W-1:0] r_open_idx, n_open_idx;
    logic [LW-1:0]      r_open_len, n_open_len;
    logic [USED_W-1:0]  r_ent_used, n_ent_used;
    logic               r_ent_ovf, n_ent_ovf;
    logic [LIMIT_W-1:0] r_limit;

    logic               r_out_vld, n_out_vld;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [INDEX_W-1:0] r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;
    logic [USED_W-1:0]  r_out_used, n_out_used;
    logic               r_out_warn, n_out_warn;
    logic               r_out_ovf, n_out_ovf;

    logic               w_out_free;
    logic               w_split;
    logic [LW-1:0]      w_new_len;
    logic [INDEX_W-1:0] w_new_idx;
    logic [EW-1:0]      w_len_a, w_len_b, w_len_c;

    assign w_out_free = !r_out_vld || i_tready;
    assign w_split    = (r_open_len != '0) &&
                        ((i_ent.idx != r_open_idx) || (r_open_len >= LW'(RUN_MAX)));
    assign w_new_len  = ((r_open_len == '0) || w_split) ? LW'(1) : r_open_len + LW'(1);
    assign w_new_idx  = ((r_open_len == '0) || w_split) ? i_ent.idx : r_open_idx;
    assign w_len_a    = EW'(r_open_len);
    assign w_len_b    = EW'(w_new_len);
    assign w_len_c    = w_len_a;

    always_comb begin
        n_state     = r_state;
        n_open_idx  = r_open_idx;
        n_open_len  = r_open_len;
        n_ent_used  = r_ent_used;
        n_ent_ovf   = r_ent_ovf;
        n_out_vld   = r_out_vld && !i_tready;
        n_out_count = r_out_count;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;
        n_out_used  = r_out_used;
        n_out_warn  = r_out_warn;
        n_out_ovf   = r_out_ovf;
        o_pop       = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty && w_out_free) begin
                    o_pop      = 1'b1;
                    n_ent_used = i_ent.used;
                    n_ent_ovf  = i_ent.ovf;
                    n_open_idx = w_new_idx;
                    n_open_len = w_new_len;
                    n_out_used = i_ent.used;
                    n_out_warn = (i_ent.used > r_limit);
                    n_out_ovf  = i_ent.ovf;
                    if (w_split) begin
                        n_out_vld   = 1'b1;
                        n_out_count = w_len_a[COUNT_W-1:0];
                        n_out_idx   = r_open_idx;
                        n_out_last  = 1'b0;
                        if (i_ent.eol) begin
                            n_state = B_SECOND;
                        end
                    end else if (i_ent.eol) begin
                        n_out_vld   = 1'b1;
                        n_out_count = w_len_b[COUNT_W-1:0];
                        n_out_idx   = w_new_idx;
                        n_out_last  = 1'b1;
                        n_open_len  = '0;
                    end
                end
            end
            B_SECOND: begin
                if (w_out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_count = w_len_c[COUNT_W-1:0];
                    n_out_idx   = r_open_idx;
                    n_out_last  = 1'b1;
                    n_out_used  = r_ent_used;
                    n_out_warn  = (r_ent_used > r_limit);
                    n_out_ovf   = r_ent_ovf;
                    n_open_len  = '0;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_open_idx <= '0;
            r_open_len <= '0;
            r_out_vld  <= 1'b0;
            r_limit    <= LIMIT_RESET;
        end else begin
            r_state    <= n_state;
            r_open_idx <= n_open_idx;
            r_open_len <= n_open_len;
            r_out_vld  <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent_used  <= n_ent_used;
        r_ent_ovf   <= n_ent_ovf;
        r_out_count <= n_out_count;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
        r_out_used  <= n_out_used;
        r_out_warn  <= n_out_warn;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_tvalid = r_out_vld;
    assign o_count  = r_out_count;
    assign o_index  = r_out_idx;
    assign o_last   = r_out_last;
    assign o_used   = r_out_used;
    assign o_warn   = r_out_warn;
    assign o_ovf    = r_out_ovf;

endmodule

>>> rtl/palette_index_run_length_encoder.sv
// Top level of the palette index run-length encoder.
//
//  port group   dir  tdata fields (lsb first)                           tlast
//  i_s_*        in   pixel_color[23:0]                                  end_of_line
//  o_m_*        out  run_count[12:0] run_index[20:13] colors_used[29:21] line_done
//                    warn_flag[30] overflow_error[31]
//  i_cfg_*      in   warn_color_limit[8:0], written when i_cfg_wr_en is high
//
//  A pixel is compared with up to colors_used palette entries, reading one RAM entry per cycle;
//  an empty palette stores it with no scan. The run builder issues one transaction per cycle
//  unless held by the sink or an empty queue; a line end after a split adds a second one.
//  Synchronous active-low reset clears control state; the palette needs no clearing pass.
//  A two-entry queue lets the lookup carry on while the output side is stalled.
module palette_index_run_length_encoder #(
    parameter int PALETTE_DEPTH = 256,
    parameter int RUN_MAX       = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // pixel_color
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // run_count, run_index, colors_used, warn, overflow
    output logic        o_m_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data
);

    import pirle_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    t_run_ent           w_push_ent, w_pop_ent;
    logic               w_push, w_full, w_pop, w_empty;
    logic [COUNT_W-1:0] w_count;
    logic [INDEX_W-1:0] w_index;
    logic [USED_W-1:0]  w_used;
    logic               w_warn, w_ovf;

    pirle_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_color  (i_s_tdata),
        .i_eol    (i_s_tlast),
        .o_push   (w_push),
        .o_ent    (w_push_ent),
        .i_full   (w_full)
    );

    pirle_fifo #(
        .WIDTH ($bits(t_run_ent)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_ent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_ent),
        .o_empty (w_empty)
    );

    pirle_back #(
        .RUN_MAX (RUN_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_empty       (w_empty),
        .i_ent         (w_pop_ent),
        .o_pop         (w_pop),
        .o_tvalid      (o_m_tvalid),
        .i_tready      (i_m_tready),
        .o_count       (w_count),
        .o_index       (w_index),
        .o_last        (o_m_tlast),
        .o_used        (w_used),
        .o_warn        (w_warn),
        .o_ovf         (w_ovf)
    );

    assign o_m_tdata = {w_ovf, w_warn, w_used, w_index, w_count};

endmodule

>>> sim/tb_palette_index_run_length_encoder.sv
// Self-checking testbench for the palette index run-length encoder.
`timescale 1ns / 100ps

module tb_palette_index_run_length_encoder;
    import pirle_pkg::*;

    localparam int PAL_DEPTH      = 256;
    localparam int RUN_LIMIT      = 4096;
    localparam int SETTLE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [INDEX_W-1:0] index;
        logic               done;
        logic [USED_W-1:0]  used;
        logic               warn;
        logic               ovf;
    } t_run_rec;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_s_tvalid    = 1'b0;
    logic               o_s_tready;
    logic [COLOR_W-1:0] i_s_tdata     = '0;
    logic               i_s_tlast     = 1'b0;
    logic               o_m_tvalid;
    logic               i_m_tready    = 1'b0;
    logic [31:0]        o_m_tdata;
    logic               o_m_tlast;
    logic               i_cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;

    // encoder state as the predictor sees it
    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    int                 pal_count  = 0;
    logic [INDEX_W-1:0] open_idx   = '0;
    int                 open_len   = 0;
    logic               ovf_seen   = 1'b0;
    logic [LIMIT_W-1:0] warn_limit = LIMIT_RESET;
    t_run_rec           runs_due [$];

    logic [COLOR_W-1:0] last_color = '0;
    int                 src_idle_pct  = 0;
    int                 sink_idle_pct = 0;
    int                 n_pixels = 0;
    int                 n_runs   = 0;
    int                 n_errors = 0;
    int                 quiet_cycles = 0;
    t_run_rec           got_run, want_run;

    palette_index_run_length_encoder #(
        .PALETTE_DEPTH(PAL_DEPTH),
        .RUN_MAX      (RUN_LIMIT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),     // pixel_color
        .i_s_tlast    (i_s_tlast),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),     // run_count, run_index, colors_used, warn, overflow
        .o_m_tlast    (o_m_tlast),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int palette_find(input logic [COLOR_W-1:0] color);
        int i;
        for (i = 0; i < pal_count; i++) begin
            if (pal_mem[i] == color) return i;
        end
        return -1;
    endfunction

    function automatic void emit_run(input int len, input logic [INDEX_W-1:0] idx,
                                     input logic done);
        t_run_rec r;
        r.count = len[COUNT_W-1:0];
        r.index = idx;
        r.done  = done;
        r.used  = pal_count[USED_W-1:0];
        r.warn  = (pal_count > warn_limit);
        r.ovf   = ovf_seen;
        runs_due.push_back(r);
    endfunction

    // palette lookup followed by run merging for one accepted pixel
    function automatic void encode_pixel(input logic [COLOR_W-1:0] color, input logic eol);
        int hit;
        logic [INDEX_W-1:0] idx;
        hit = palette_find(color);
        if (hit >= 0) begin
            idx = hit[INDEX_W-1:0];
        end else if (pal_count == PAL_DEPTH) begin
            ovf_seen = 1'b1;
            idx = '0;
        end else begin
            pal_mem[pal_count] = color;
            idx = pal_count[INDEX_W-1:0];
            pal_count++;
        end
        if (open_len == 0) begin
            open_idx = idx;
            open_len = 1;
        end else if (idx != open_idx || open_len >= RUN_LIMIT) begin
            emit_run(open_len, open_idx, 1'b0);
            open_idx = idx;
            open_len = 1;
        end else begin
            open_len++;
        end
        if (eol) begin
            emit_run(open_len, open_idx, 1'b1);
            open_len = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic eol);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= COLOR_W'($urandom);
            i_s_tlast  <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= color;
        i_s_tlast  <= eol;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        encode_pixel(color, eol);
        last_color = color;
        n_pixels++;
        @(negedge i_clk);
    endtask

    // block idle: all runs out and any pixel still in lookup finished
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_warn_limit(input logic [LIMIT_W-1:0] limit);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        warn_limit = limit;
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // field extremes, known and new colours, one-pixel line; passes the reset limit
    task automatic test_basic_runs();
        int i;
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h555555, 1'b0);
        send_pixel(24'hAAAAAA, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        for (i = 0; i < 10; i++) send_pixel(24'h000002 << (2 * i), i == 9);
        send_pixel(24'hFFFFFF, 1'b1);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h000000, 1'b1);
    endtask

    // limit of zero, then the boundary where colours used equals the limit
    task automatic test_warn_limit();
        settle();
        set_warn_limit(9'd0);
        send_pixel(24'hFFFFFF, 1'b1);
        settle();
        set_warn_limit(9'd17);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'h123456, 1'b1);
    endtask

    // mostly repeats and known colours so runs form; now and then a long run
    task automatic test_random_lines(input int n_items, input int pct_new);
        int sent, reps, k;
        logic [COLOR_W-1:0] color;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(99);
            if (k < 50)
                color = last_color;
            else if (k < 100 - pct_new && pal_count > 0)
                color = pal_mem[$urandom_range(pal_count - 1)];
            else
                color = COLOR_W'($urandom);
            reps = ($urandom_range(99) < 4) ? $urandom_range(150, 20) : 1;
            repeat (reps - 1) send_pixel(color, 1'b0);
            send_pixel(color, $urandom_range(99) < 12);
            sent += reps;
        end
    endtask

    task automatic test_random_phase(input logic [LIMIT_W-1:0] limit, input int n_items);
        settle();
        set_warn_limit(limit);
        test_random_lines(n_items, 10);
    endtask

    task automatic test_palette_overflow();
        logic [COLOR_W-1:0] color;
        settle();
        set_warn_limit(9'd256);
        while (pal_count < PAL_DEPTH) begin
            color = COLOR_W'($urandom);
            if (palette_find(color) < 0) send_pixel(color, $urandom_range(99) < 10);
        end
        send_pixel(pal_mem[PAL_DEPTH-1], 1'b1);
        settle();
        set_warn_limit(9'd255);
        do color = COLOR_W'($urandom); while (palette_find(color) >= 0);
        send_pixel(color, 1'b1);
        test_random_lines(100, 30);
        send_pixel(last_color, 1'b1);
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_run.count = o_m_tdata[12:0];
            got_run.index = o_m_tdata[20:13];
            got_run.used  = o_m_tdata[29:21];
            got_run.warn  = o_m_tdata[30];
            got_run.ovf   = o_m_tdata[31];
            got_run.done  = o_m_tlast;
            if (runs_due.size() == 0) begin
                report_mismatch($sformatf("unexpected run count=%0d index=%0d",
                                          got_run.count, got_run.index));
            end else begin
                want_run = runs_due.pop_front();
                n_runs++;
                if (got_run.count != want_run.count)
                    report_mismatch($sformatf("run %0d run_count %0d, want %0d",
                                              n_runs, got_run.count, want_run.count));
                if (got_run.index != want_run.index)
                    report_mismatch($sformatf("run %0d run_index %0d, want %0d",
                                              n_runs, got_run.index, want_run.index));
                if (got_run.done != want_run.done)
                    report_mismatch($sformatf("run %0d line_done %0d, want %0d",
                                              n_runs, got_run.done, want_run.done));
                if (got_run.used != want_run.used)
                    report_mismatch($sformatf("run %0d colors_used %0d, want %0d",
                                              n_runs, got_run.used, want_run.used));
                if (got_run.warn != want_run.warn)
                    report_mismatch($sformatf("run %0d warn_flag %0d, want %0d",
                                              n_runs, got_run.warn, want_run.warn));
                if (got_run.ovf != want_run.ovf)
                    report_mismatch($sformatf("run %0d overflow_error %0d, want %0d",
                                              n_runs, got_run.ovf, want_run.ovf));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d runs outstanding",
                     quiet_cycles, runs_due.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(7, 69);
        test_basic_runs();
        test_warn_limit();
        test_random_phase(9'd1, 150);
        set_idling(69, 7);
        test_random_phase(LIMIT_W'(pal_count + $urandom_range(12, 1)), 150);
        set_idling(0, 0);
        test_random_phase(9'd256, 120);
        test_palette_overflow();
        settle();
        $display("Encoded %0d pixels into %0d runs; palette reached %0d colours, overflow %0d",
                 n_pixels, n_runs, pal_count, ovf_seen);
        $display("Covered warning limits 16, 0, 17, 1, 255, 256 and a full palette");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pirle_pkg.sv
rtl/pirle_ram.sv
rtl/pirle_fifo.sv
rtl/pirle_front.sv
rtl/pirle_back.sv
rtl/palette_index_run_length_encoder.sv
sim/tb_palette_index_run_length_encoder.sv
